>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Needs nothing else; each takes a label, clock and two expressions, most a reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hdl/sti_pkg.sv
// Types and codes of the sorted table block.
// No dependencies; used by the top level, the compare unit and the checker.
`default_nettype none

package sti_pkg;

   localparam int FUNC_W  = 2;
   localparam int KEY_W   = 32;
   localparam int COUNT_W = 5;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]       func;
      logic signed [KEY_W-1:0] key_value;
   } req_type;

   typedef struct packed {
      logic                    ok;
      logic signed [KEY_W-1:0] entry_value;
      logic [COUNT_W-1:0]      entry_count;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_type;

endpackage

`default_nettype wire

>>> hdl/sti_cmp.sv
// Shared compare unit: signed less-than and equality of a stored entry and the key.
// Uses sti_pkg for widths and the result struct.
`default_nettype none

module sti_cmp import sti_pkg::*; (
   input  logic signed [KEY_W-1:0] entry,
   input  logic signed [KEY_W-1:0] key,
   output cmp_type                 res
);

   assign res.lt = (entry < key);
   assign res.eq = (entry == key);

endmodule

`default_nettype wire

>>> hdl/sorted_table_insert_remove_top.sv
// Sorted table: keeps up to CAPACITY signed values in ascending order.
// Request channel (req_valid/req_stall/req) carries func and key_value; an item
// is taken when req_valid is high and req_stall low. req_stall stays high while
// an item is in work. Result channel (rsp_valid/rsp_stall/rsp) carries ok,
// entry_value, entry_count and last; last marks the final result of an item.
// One item at a time. The table sits in a single-port-write, single-port-read
// memory with registered read data; one compare unit walks it one entry a cycle.
//   insert: walk down from the top, moving larger-or-equal entries up, then write
//   remove: search up from the bottom, then shift the later entries down
//   dump:   one result per entry, in ascending order, last on the top entry
//   full insert, empty remove/dump, unused code: straight to a result, ok low
// Reset (synchronous) empties the table and drops any pending result; the
// memory contents are not cleared. While a result is pending and rsp_stall is high,
// the result register holds and no new result is made, including mid-dump.
`default_nettype none

module sorted_table_insert_remove_top import sti_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int WW = CW + 1;
   localparam logic [WW-1:0] CAP_W = WW'(CAPACITY);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_INS  = 3'd1;
   localparam logic [2:0] S_INS0 = 3'd2;
   localparam logic [2:0] S_RMF  = 3'd3;
   localparam logic [2:0] S_RMS  = 3'd4;
   localparam logic [2:0] S_DUMP = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic [CW-1:0]           count_ff, count_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic                    res_ok_ff, res_ok_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [KEY_W-1:0]        mem [CAPACITY];
   logic signed [KEY_W-1:0] rd_data_ff;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [KEY_W-1:0]        wr_data;

   logic [WW-1:0] idx_w;
   logic [WW-1:0] cnt_w;
   logic [WW-1:0] cnt_m1;
   logic          at_last;
   logic          out_free;
   cmp_type       cmp;

   // out-of-range addresses only occur on reads whose data is never used
   function automatic logic [AW-1:0] addr_of(input logic [WW-1:0] a);
      return (a < CAP_W) ? a[AW-1:0] : '0;
   endfunction

   sti_cmp u_cmp (
      .entry (rd_data_ff),
      .key   (key_ff),
      .res   (cmp)
   );

   assign idx_w    = WW'(idx_ff);
   assign cnt_w    = WW'(count_ff);
   assign cnt_m1   = cnt_w - 1'b1;
   assign at_last  = (idx_w == cnt_m1);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      res_ok_in    = res_ok_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = key_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in    = req.key_value;
               res_ok_in = 1'b0;
               state_in  = S_DONE;
               case (req.func)
                  FUNC_INSERT: begin
                     if (cnt_w == CAP_W) begin
                        state_in = S_DONE;
                     end else if (count_ff == '0) begin
                        state_in = S_INS0;
                     end else begin
                        idx_in   = cnt_m1[AW-1:0];
                        rd_en    = 1'b1;
                        rd_addr  = cnt_m1[AW-1:0];
                        state_in = S_INS;
                     end
                  end
                  FUNC_REMOVE: begin
                     if (count_ff != '0) begin
                        idx_in   = '0;
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = S_RMF;
                     end
                  end
                  FUNC_DUMP: begin
                     if (count_ff == '0) begin
                        key_in = '0;
                     end else begin
                        idx_in   = '0;
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = S_DUMP;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_INS: begin
            // walk down from the top, moving each larger-or-equal entry up one
            wr_en   = 1'b1;
            wr_addr = addr_of(idx_w + 1'b1);
            if (cmp.lt) begin
               wr_data   = key_ff;
               count_in  = CW'(cnt_w + 1'b1);
               res_ok_in = 1'b1;
               state_in  = S_DONE;
            end else begin
               wr_data = rd_data_ff;
               if (idx_ff == '0) begin
                  state_in = S_INS0;
               end else begin
                  idx_in  = idx_ff - 1'b1;
                  rd_en   = 1'b1;
                  rd_addr = idx_ff - 1'b1;
               end
            end
         end
         S_INS0: begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = key_ff;
            count_in  = CW'(cnt_w + 1'b1);
            res_ok_in = 1'b1;
            state_in  = S_DONE;
         end
         S_RMF: begin
            // prefetch the next entry: search step or first shift
            rd_en   = 1'b1;
            rd_addr = addr_of(idx_w + 1'b1);
            if (cmp.eq) begin
               if (at_last) begin
                  count_in  = CW'(cnt_m1);
                  res_ok_in = 1'b1;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_RMS;
               end
            end else if (at_last) begin
               state_in = S_DONE;
            end else begin
               idx_in = AW'(idx_w + 1'b1);
            end
         end
         S_RMS: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data_ff;
            if ((idx_w + 2'd2) == cnt_w) begin
               count_in  = CW'(cnt_m1);
               res_ok_in = 1'b1;
               state_in  = S_DONE;
            end else begin
               idx_in  = AW'(idx_w + 1'b1);
               rd_en   = 1'b1;
               rd_addr = addr_of(idx_w + 2'd2);
            end
         end
         S_DUMP: begin
            if (out_free) begin
               rsp_in.ok          = 1'b1;
               rsp_in.entry_value = rd_data_ff;
               rsp_in.entry_count = COUNT_W'(count_ff);
               rsp_in.last        = at_last;
               rsp_valid_in       = 1'b1;
               if (at_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in  = AW'(idx_w + 1'b1);
                  rd_en   = 1'b1;
                  rd_addr = addr_of(idx_w + 1'b1);
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_in.ok          = res_ok_ff;
               rsp_in.entry_value = key_ff;
               rsp_in.entry_count = COUNT_W'(count_ff);
               rsp_in.last        = 1'b1;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      key_ff    <= key_in;
      res_ok_ff <= res_ok_in;
      rsp_ff    <= rsp_in;
   end

   // table memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> hdl/sti_checker.sv
// Port-level checker for the sorted table, bound to the top level.
// Uses sti_pkg for the payload types and assert_macros.svh for the assertions.
`default_nettype none
`include "assert_macros.svh"

module sti_checker import sti_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp
);

   logic req_take;
   logic req_bits;

   assign req_take = req_valid && !req_stall;
   assign req_bits = ^req;

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
   // reset drops any pending result
   `ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid)
   // one item at a time: busy right after taking an item
   `ASSERT_NEXT(a_busy_after_take, clock, reset, req_take && (req_bits || !req_bits), req_stall)
   // only dump entries come in runs; a refused or empty result is always final
   `ASSERT_IMPLIES(a_fail_is_last, clock, reset, rsp_valid && !rsp.ok, rsp.last)

endmodule

bind sorted_table_insert_remove_top sti_checker u_sti_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

`default_nettype wire
